### hw/rtl/eva_pkg.sv
// Package with the types, codes and constants of the encoder value accelerator.
`timescale 1ns / 1ps

package eva_pkg;

	localparam int unsigned ACCEL_STEPS = 5;
	localparam logic [2:0] IDX_LAST = 3'(ACCEL_STEPS - 1);

	localparam logic signed [31:0] FIXED_SPEED = 32'sd1500;
	localparam logic signed [31:0] VEL_MAX = 32'sh7fff_ffff;
	localparam logic signed [31:0] VEL_MIN = 32'sh8000_0000;

	localparam logic [1:0] DIR_NONE = 2'b00;
	localparam logic [1:0] DIR_CW = 2'b01;
	localparam logic [1:0] DIR_CCW = 2'b11;

	typedef enum logic [1:0] {
		REG_RAMP_EN = 2'd0,
		REG_MAX_VELOCITY = 2'd1,
		REG_MIN_VALUE = 2'd2,
		REG_MAX_VALUE = 2'd3
	} eva_reg_t;

	typedef struct packed {
		logic ramp_en;
		logic [15:0] max_velocity;
		logic signed [31:0] min_value;
		logic signed [31:0] max_value;
	} eva_cfg_t;

	typedef struct packed {
		logic signed [31:0] cur;
		logic signed [31:0] vel;
		logic [1:0] last_dir;
		logic [2:0] idx;
	} eva_state_t;

	// Velocity increment for each acceleration index; later indexes keep the last step.
	function automatic logic [8:0] inc_lookup(input logic [2:0] idx);
		logic [8:0] inc;
		case (idx)
			3'd0: inc = 9'd0;
			3'd1: inc = 9'd10;
			3'd2: inc = 9'd40;
			3'd3: inc = 9'd120;
			default: inc = 9'd320;
		endcase
		return inc;
	endfunction

endpackage

### hw/rtl/eva_core.sv
// Next-state logic for one encoder step: velocity update, velocity limit and value clamp.
`timescale 1ns / 1ps

module eva_core import eva_pkg::*; (
	input  eva_cfg_t   cfg,
	input  eva_state_t st,
	input  logic [1:0] step_dir,
	output eva_state_t nxt
);

	logic is_cw;
	logic is_ccw;
	logic moving;
	logic move;
	logic [1:0] dir_code;
	logic signed [31:0] vel_base;
	logic [8:0] inc;
	logic signed [32:0] inc_w;
	logic signed [32:0] vel_sum;
	logic signed [31:0] vel_new;
	logic signed [32:0] vel_w;
	logic signed [32:0] vlim_w;
	logic signed [32:0] step_w;
	logic signed [33:0] sum_w;
	logic signed [33:0] min_w;
	logic signed [33:0] max_w;
	logic signed [31:0] cur_new;

	assign is_cw = (step_dir == DIR_CW);
	assign is_ccw = (step_dir == DIR_CCW);
	assign moving = is_cw | is_ccw;
	assign dir_code = moving ? step_dir : DIR_NONE;

	always_comb begin
		nxt.last_dir = st.last_dir;
		nxt.idx = st.idx;
		vel_base = st.vel;
		vel_new = st.vel;
		move = 1'b0;
		inc = 9'd0;
		inc_w = '0;
		vel_sum = '0;
		if (!cfg.ramp_en) begin
			if (moving) begin
				vel_new = is_cw ? FIXED_SPEED : -FIXED_SPEED;
				move = 1'b1;
			end
		end else if (!moving) begin
			vel_new = (st.vel > 32'sd0) ? st.vel - 32'sd1 : st.vel + 32'sd1;
		end else begin
			if (st.last_dir == dir_code) begin
				nxt.idx = (st.idx == IDX_LAST) ? 3'd0 : st.idx + 3'd1;
			end else begin
				nxt.idx = 3'd0;
				vel_base = '0;
			end
			nxt.last_dir = dir_code;
			inc = inc_lookup(nxt.idx);
			inc_w = $signed({24'd0, inc});
			vel_sum = $signed({vel_base[31], vel_base}) + (is_cw ? inc_w : -inc_w);
			if (vel_sum[32] != vel_sum[31]) begin
				vel_new = vel_sum[32] ? VEL_MIN : VEL_MAX;
			end else begin
				vel_new = vel_sum[31:0];
			end
			move = 1'b1;
		end
		nxt.vel = vel_new;

		vel_w = $signed({vel_new[31], vel_new});
		vlim_w = $signed({17'd0, cfg.max_velocity});
		if (vel_w > vlim_w) begin
			step_w = vlim_w;
		end else if (vel_w < -vlim_w) begin
			step_w = -vlim_w;
		end else begin
			step_w = vel_w;
		end
		sum_w = $signed({{2{st.cur[31]}}, st.cur}) + $signed({step_w[32], step_w});
		min_w = $signed({{2{cfg.min_value[31]}}, cfg.min_value});
		max_w = $signed({{2{cfg.max_value[31]}}, cfg.max_value});
		if (sum_w < min_w) begin
			cur_new = cfg.min_value;
		end else if (sum_w > max_w) begin
			cur_new = cfg.max_value;
		end else begin
			cur_new = sum_w[31:0];
		end
		nxt.cur = move ? cur_new : st.cur;
	end

endmodule

### hw/rtl/encoder_value_accelerator.sv
// Top level of the encoder value accelerator: handshakes, registers and state.
//
// One input transaction carries a decoded encoder step on step_dir (1 clockwise,
// -1 counterclockwise, 0 or the unused code for no movement). Each one yields
// exactly one output transaction with the new value, the value before the step
// and the signed velocity after it. Both channels take a transaction when valid
// is high and stall is low.
// The step is held in an input register; the new state is computed from it and
// loaded into the output register together with the state update when the
// output register is free. One step is taken every cycle while the receiver
// does not stall.
// When the receiver stalls, the result is held and the input register still
// fills; in_stall rises only when both registers hold a step.
// The configuration channel is always ready and should be written only while
// no transaction is in flight.
// Reset clears the value, velocity, direction and index, empties both registers
// and loads fixed mode, a velocity limit of 1500 and limits of 0 and 65535.
`timescale 1ns / 1ps

module encoder_value_accelerator import eva_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [1:0]  step_dir,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] value,
	output logic signed [31:0] previous_value,
	output logic signed [31:0] speed,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [31:0]        cfg_data
);

	eva_cfg_t cfg_q;
	eva_state_t state_q;
	eva_state_t state_nxt;
	logic valid_s1;
	logic [1:0] step_dir_s1;
	logic valid_s2;
	logic signed [31:0] value_s2;
	logic signed [31:0] prev_s2;
	logic signed [31:0] speed_s2;
	logic out_free;
	logic adv;
	logic in_take;

	assign cfg_ready = 1'b1;
	assign out_free = !valid_s2 || !out_stall;
	assign adv = valid_s1 && out_free;
	assign in_stall = valid_s1 && !out_free;
	assign in_take = in_valid && !in_stall;

	eva_core u_core (
		.cfg      (cfg_q),
		.st       (state_q),
		.step_dir (step_dir_s1),
		.nxt      (state_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.ramp_en <= 1'b0;
			cfg_q.max_velocity <= 16'd1500;
			cfg_q.min_value <= 32'sd0;
			cfg_q.max_value <= 32'sd65535;
		end else if (cfg_valid && cfg_ready) begin
			case (eva_reg_t'(cfg_index))
				REG_RAMP_EN: cfg_q.ramp_en <= cfg_data[0];
				REG_MAX_VELOCITY: cfg_q.max_velocity <= cfg_data[15:0];
				REG_MIN_VALUE: cfg_q.min_value <= $signed(cfg_data);
				REG_MAX_VALUE: cfg_q.max_value <= $signed(cfg_data);
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (adv) begin
				state_q <= state_nxt;
			end
			if (in_take) begin
				valid_s1 <= 1'b1;
			end else if (adv) begin
				valid_s1 <= 1'b0;
			end
			if (out_free) begin
				valid_s2 <= adv;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			step_dir_s1 <= step_dir;
		end
		if (adv) begin
			value_s2 <= state_nxt.cur;
			prev_s2 <= state_q.cur;
			speed_s2 <= state_nxt.vel;
		end
	end

	assign out_valid = valid_s2;
	assign value = value_s2;
	assign previous_value = prev_s2;
	assign speed = speed_s2;

	// Each result reports the value held before its own state update.
	a_prev_chain: assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> (out_valid && previous_value == $past(state_q.cur)))
		else $error("previous_value does not match the value before the step");

	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.idx <= IDX_LAST)
		else $error("acceleration index out of range");

	a_dir_code: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.last_dir == DIR_NONE || state_q.last_dir == DIR_CW ||
		state_q.last_dir == DIR_CCW)
		else $error("last direction holds an invalid code");

	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && valid_s2))
		else $error("input stalled while a register is free");

endmodule
